@@ sv/infix_to_postfix_converter_defines.svh @@
// Assertion macros for the infix-to-postfix converter checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, masked during reset
`define I2P_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2p assertion failed");

// next-cycle implication, masked during reset
`define I2P_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2p assertion failed");

// next-cycle implication, live through reset
`define I2P_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("i2p reset assertion failed");

`endif

@@ sv/i2p_pkg.sv @@
// Shared types, character codes and decode helpers for the infix-to-postfix converter.
// No dependencies.
`default_nettype none

package i2p_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_symbol;
    } t_in;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       out_last;
        logic [1:0] error_code;
    } t_out;

    typedef enum logic [2:0] {
        K_LETTER,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] sym;   // operator, opener, or the opener a closer wants
        logic [1:0] prio;
        logic       fin;
    } t_cmd;

    localparam logic [1:0] ERR_OK  = 2'd0;
    localparam logic [1:0] ERR_OVF = 2'd1;
    localparam logic [1:0] ERR_UNM = 2'd2;
    localparam logic [1:0] ERR_UNK = 2'd3;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    function automatic logic [1:0] f_prio(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_CARET || c == CH_DOLLAR) begin
            p = 2'd3;
        end
        return p;
    endfunction

    function automatic logic f_is_opener(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
    endfunction

endpackage

`default_nettype wire

@@ sv/i2p_fifo.sv @@
// Small flop-based queue, power-of-two depth, used for commands and results.
// No dependencies.
`default_nettype none

module i2p_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wp  = wr_en ? AW'(r_wp + 1'b1) : r_wp;
        n_rp  = rd_en ? AW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (rd_en && !wr_en) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/i2p_front.sv @@
// Front end: classifies one input character into a stack command.
// Depends on i2p_pkg.
`default_nettype none

module i2p_front (
    input  wire i2p_pkg::t_in i_item,
    output i2p_pkg::t_cmd     o_cmd
);

    logic [7:0] sym;
    logic [1:0] prio;
    logic       is_letter;
    logic       is_closer;

    assign sym       = i_item.symbol;
    assign prio      = i2p_pkg::f_prio(sym);
    assign is_letter = (sym >= i2p_pkg::CH_UP_A && sym <= i2p_pkg::CH_UP_Z)
                    || (sym >= i2p_pkg::CH_LO_A && sym <= i2p_pkg::CH_LO_Z);
    assign is_closer = (sym == i2p_pkg::CH_RPAREN) || (sym == i2p_pkg::CH_RBRACK)
                    || (sym == i2p_pkg::CH_RBRACE);

    always_comb begin
        o_cmd.sym  = sym;
        o_cmd.prio = prio;
        o_cmd.fin  = i_item.final_symbol;
        priority if (is_letter) begin
            o_cmd.kind = i2p_pkg::K_LETTER;
        end else if (i2p_pkg::f_is_opener(sym)) begin
            o_cmd.kind = i2p_pkg::K_OPEN;
        end else if (is_closer) begin
            o_cmd.kind = i2p_pkg::K_CLOSE;
            // carry the opener this closer must meet
            priority if (sym == i2p_pkg::CH_RPAREN) begin
                o_cmd.sym = i2p_pkg::CH_LPAREN;
            end else if (sym == i2p_pkg::CH_RBRACK) begin
                o_cmd.sym = i2p_pkg::CH_LBRACK;
            end else begin
                o_cmd.sym = i2p_pkg::CH_LBRACE;
            end
        end else if (prio != 2'd0) begin
            o_cmd.kind = i2p_pkg::K_OPER;
        end else begin
            o_cmd.kind = i2p_pkg::K_BAD;
        end
    end

endmodule

`default_nettype wire

@@ sv/i2p_back.sv @@
// Back end: operator stack and sequencer that executes commands and emits result words.
// Depends on i2p_pkg.
`default_nettype none

module i2p_back #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire i2p_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output i2p_pkg::t_out      o_res
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLOSE = 5'b00010,
        S_OPER  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_LAST  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    i2p_pkg::t_cmd r_cmd, n_cmd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_stk [STACK_DEPTH];
    logic          r_stray, n_stray;
    logic          r_hold_vld, n_hold_vld;
    i2p_pkg::t_out r_hold, n_hold;

    logic [CW-1:0] cnt_m1;
    logic [7:0]    top;
    logic          stk_empty, stk_full, go;
    logic          em_vld;
    logic [7:0]    em_sym;
    logic [1:0]    em_err;
    logic          do_push, do_pop, cur_fin, last_out;
    logic [7:0]    push_sym;

    assign cnt_m1    = CW'(r_cnt - 1'b1);
    assign top       = r_stk[cnt_m1[SW-1:0]];
    assign stk_empty = (r_cnt == '0);
    assign stk_full  = (r_cnt == CW'(STACK_DEPTH));
    // stall the whole sequencer while the result queue has no room
    assign go        = !i_res_full;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_stray   = r_stray;
        em_vld    = 1'b0;
        em_sym    = 8'd0;
        em_err    = i2p_pkg::ERR_OK;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_sym  = r_cmd.sym;
        o_cmd_pop = 1'b0;
        cur_fin   = r_cmd.fin;
        last_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                cur_fin = i_cmd.fin;
                if (go && !i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_stray   = 1'b0;
                    n_state   = i_cmd.fin ? S_FLUSH : S_IDLE;
                    unique case (i_cmd.kind)
                        i2p_pkg::K_LETTER: begin
                            em_vld = 1'b1;
                            em_sym = i_cmd.sym;
                        end
                        i2p_pkg::K_OPEN: begin
                            if (stk_full) begin
                                em_vld = 1'b1;
                                em_err = i2p_pkg::ERR_OVF;
                            end else begin
                                do_push  = 1'b1;
                                push_sym = i_cmd.sym;
                            end
                        end
                        i2p_pkg::K_CLOSE: begin
                            n_state = S_CLOSE;
                        end
                        i2p_pkg::K_OPER: begin
                            n_state = S_OPER;
                        end
                        default: begin
                            em_vld = 1'b1;
                            em_err = i2p_pkg::ERR_UNK;
                        end
                    endcase
                end
            end
            S_CLOSE: begin
                if (go) begin
                    if (stk_empty) begin
                        em_vld  = 1'b1;
                        em_err  = i2p_pkg::ERR_UNM;
                        n_state = r_cmd.fin ? S_FLUSH : S_IDLE;
                    end else begin
                        do_pop = 1'b1;
                        priority if (top == r_cmd.sym) begin
                            n_state = r_cmd.fin ? S_FLUSH : S_IDLE;
                        end else if (i2p_pkg::f_is_opener(top)) begin
                            // wrong opener: drop it and flag
                            em_vld  = 1'b1;
                            em_err  = i2p_pkg::ERR_UNM;
                            n_state = r_cmd.fin ? S_FLUSH : S_IDLE;
                        end else begin
                            em_vld = 1'b1;
                            em_sym = top;
                        end
                    end
                end
            end
            S_OPER: begin
                if (go) begin
                    if (!stk_empty && (i2p_pkg::f_prio(top) >= r_cmd.prio)) begin
                        do_pop = 1'b1;
                        em_vld = 1'b1;
                        em_sym = top;
                    end else begin
                        if (stk_full) begin
                            em_vld = 1'b1;
                            em_err = i2p_pkg::ERR_OVF;
                        end else begin
                            do_push = 1'b1;
                        end
                        n_state = r_cmd.fin ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (go) begin
                    if (!stk_empty) begin
                        do_pop = 1'b1;
                        if (i2p_pkg::f_is_opener(top)) begin
                            n_stray = 1'b1;
                        end else begin
                            em_vld = 1'b1;
                            em_sym = top;
                        end
                    end else begin
                        if (r_stray) begin
                            em_vld = 1'b1;
                            em_err = i2p_pkg::ERR_UNM;
                        end
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (go) begin
                    last_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (do_push) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (do_pop) begin
            n_cnt = cnt_m1;
        end
    end

    // final item: hold back one word so the last one can carry out_last
    always_comb begin
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        o_res_push = 1'b0;
        o_res      = '{out_symbol: 8'd0, out_last: 1'b0, error_code: i2p_pkg::ERR_OK};
        if (last_out) begin
            o_res_push = 1'b1;
            n_hold_vld = 1'b0;
            if (r_hold_vld) begin
                o_res = '{out_symbol: r_hold.out_symbol, out_last: 1'b1,
                          error_code: r_hold.error_code};
            end else begin
                o_res = '{out_symbol: 8'd0, out_last: 1'b1, error_code: i2p_pkg::ERR_OK};
            end
        end else if (em_vld) begin
            if (cur_fin) begin
                n_hold     = '{out_symbol: em_sym, out_last: 1'b0, error_code: em_err};
                n_hold_vld = 1'b1;
                o_res_push = r_hold_vld;
                o_res      = r_hold;
            end else begin
                o_res_push = 1'b1;
                o_res      = '{out_symbol: em_sym, out_last: 1'b0, error_code: em_err};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_stray    <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_stray    <= n_stray;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_hold <= n_hold;
        if (do_push) begin
            r_stk[r_cnt[SW-1:0]] <= push_sym;
        end
    end

endmodule

`default_nettype wire

@@ sv/infix_to_postfix_converter.sv @@
// Top level of the infix-to-postfix converter: front decode, command queue,
// stack sequencer, result queue. Depends on i2p_pkg, i2p_front, i2p_fifo, i2p_back.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------
//   input     | push / full        | i_item   (symbol, final_symbol)
//   result    | pop  / empty       | o_result (out_symbol, out_last, error_code)
//
// Letters, openers and unknown characters are handled straight from the idle state;
// operators first pop every stacked operator of equal or higher priority, closers emit
// operators until the opener. A final item then flushes the remaining stack entries
// and emits the end-of-expression word; the stack sequencer sets the rate.
// Synchronous active-low reset empties both queues and the stack.
// A full result queue stalls the sequencer; the command queue keeps taking words.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire i2p_pkg::t_in i_item,
    output logic              empty,
    input  wire logic         pop,
    output i2p_pkg::t_out     o_result
);

    localparam int CMD_W = $bits(i2p_pkg::t_cmd);
    localparam int RES_W = $bits(i2p_pkg::t_out);

    i2p_pkg::t_cmd    dec_cmd;
    i2p_pkg::t_cmd    q_cmd;
    logic [CMD_W-1:0] q_cmd_bits;
    logic             cmd_empty, cmd_pop;
    logic             res_full, res_push;
    i2p_pkg::t_out    res;
    logic [RES_W-1:0] res_bits;

    i2p_front u_front (
        .i_item (i_item),
        .o_cmd  (dec_cmd)
    );

    i2p_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (i2p_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (q_cmd_bits),
        .o_empty (cmd_empty)
    );

    assign q_cmd = q_cmd_bits;

    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    i2p_fifo #(
        .WIDTH (RES_W),
        .DEPTH (i2p_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign o_result = res_bits;

endmodule

`default_nettype wire

@@ sv/i2p_checker.sv @@
// Port-level checks for the infix-to-postfix converter, bound to the top level.
// Depends on i2p_pkg and infix_to_postfix_converter_defines.svh.
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module i2p_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire i2p_pkg::t_out o_result
);

    logic has_err;
    logic bare_ok;

    assign has_err = !empty && (o_result.error_code != i2p_pkg::ERR_OK);
    assign bare_ok = !empty && (o_result.error_code == i2p_pkg::ERR_OK)
                  && (o_result.out_symbol == 8'd0);

    // reset leaves both queues empty
    `I2P_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n, empty && !full)
    // an error word never carries a character
    `I2P_ASSERT_IMP(a_err_no_sym, i_clk, i_rst_n, has_err, o_result.out_symbol == 8'd0)
    // a word with no character and no error can only be the end-of-expression word
    `I2P_ASSERT_IMP(a_bare_is_last, i_clk, i_rst_n, bare_ok, o_result.out_last)
    // a waiting word holds until taken
    `I2P_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result))

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);

`default_nettype wire
